FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the checker file spwm_checker.sv
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only out of reset
`define SPWM_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// property checked on every edge, reset included
`define SPWM_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

FILE: hdl/spwm_pkg.sv
// ---------------------------------------------------------------------------
// spwm_pkg
// constants, rom builders and controller/datapath interface types
// ---------------------------------------------------------------------------
package spwm_pkg;

    localparam int SAMPLE_RATE_HZ     = 10000;
    localparam int SINE_TABLE_DEPTH   = 256;
    localparam int SINE_FRACTION_BITS = 16;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    localparam int FREQ_W   = 8;
    localparam int INTEN_W  = 8;
    localparam int FS_W     = 8;
    localparam int DUTY_W   = 16;
    localparam int PHASE_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int MAG_W      = SINE_FRACTION_BITS + 1;
    localparam int IDX_W      = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD1_W    = DUTY_W + INTEN_W;
    localparam int PROD2_W    = PROD1_W + MAG_W;
    localparam int QSRC_W     = PROD2_W - SINE_FRACTION_BITS;
    localparam int LIM_W      = DUTY_W + 1 + FS_W;
    localparam int DIV_STEPS  = DUTY_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);
    localparam int FREQ_DEPTH = 1 << FREQ_W;

    localparam logic [CFG_IDX_W-1:0] CFG_INTENSITY_FULL_SCALE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX             = 1'b1;

    localparam logic [FS_W-1:0]   FS_RESET       = 8'd10;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RESET = 16'd1023;

    typedef logic [MAG_W-1:0]   sine_rom_t [0:SINE_TABLE_DEPTH];
    typedef logic [PHASE_W-1:0] inc_rom_t  [0:FREQ_DEPTH-1];

    typedef struct packed {
        logic load;
        logic mul;
        logic prep;
        logic step;
        logic emit;
    } spwm_cmd_t;

    typedef struct packed {
        logic div_last;
    } spwm_status_t;

    function automatic longint unsigned taylor_sub(input longint unsigned a,
                                                   input longint unsigned b);
        return (a >= b) ? a - b : 64'd0;
    endfunction

    // quarter-wave sine entry, taylor series to x^17 in q30
    function automatic logic [MAG_W-1:0] sine_entry(input longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned r;
        x    = (k * HALF_PI_Q30 + longint'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;
        sum  = taylor_sub(sum, term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = taylor_sub(sum, term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = taylor_sub(sum, term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd210;
        sum  = taylor_sub(sum, term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + term;
        r = (sum + (64'd1 << (29 - SINE_FRACTION_BITS))) >> (30 - SINE_FRACTION_BITS);
        if (r > (64'd1 << SINE_FRACTION_BITS)) begin
            r = 64'd1 << SINE_FRACTION_BITS;
        end
        return r[MAG_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            rom[k] = sine_entry(longint'(k));
        end
        return rom;
    endfunction

    // phase step per sample, frequency zero runs as 1 hz
    function automatic inc_rom_t build_inc_rom();
        inc_rom_t        rom;
        longint unsigned f;
        longint unsigned v;
        for (int i = 0; i < FREQ_DEPTH; i++) begin
            f = (i == 0) ? 64'd1 : longint'(i);
            v = (f << PHASE_W) / SAMPLE_RATE_HZ;
            rom[i] = v[PHASE_W-1:0];
        end
        return rom;
    endfunction

endpackage

FILE: hdl/spwm_ctrl.sv
// ---------------------------------------------------------------------------
// spwm_ctrl
// sequencer: accept, multiply, divide setup, divide steps, result handoff
// ---------------------------------------------------------------------------
module spwm_ctrl import spwm_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  logic         m_ready,
    output spwm_cmd_t    cmd,
    input  spwm_status_t status
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_PREP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_HOLD = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!out_valid_reg || m_ready) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

FILE: hdl/spwm_datapath.sv
// ---------------------------------------------------------------------------
// spwm_datapath
// phase accumulator, sine rom, scaling multipliers, radix-2 divider, output
// ---------------------------------------------------------------------------
module spwm_datapath import spwm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [FREQ_W-1:0]     s_frequency_hz,
    input  logic [INTEN_W-1:0]    s_intensity,
    output logic [DUTY_W-1:0]     m_duty,
    output logic                  m_direction,
    input  spwm_cmd_t             cmd,
    output spwm_status_t          status
);

    localparam sine_rom_t SINE_ROM      = build_sine_rom();
    localparam inc_rom_t  PHASE_INC_ROM = build_inc_rom();
    localparam int        IDX_PROD_W    = 30 + IDX_W;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [FS_W-1:0]    fs_reg, fs_next;
    logic [DUTY_W-1:0]  dm_reg, dm_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [MAG_W-1:0]   mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic               inten_nz_reg, inten_nz_next;
    logic [PROD1_W-1:0] p1_reg, p1_next;
    logic [LIM_W-1:0]   lim_reg, lim_next;
    logic [PROD2_W-1:0] p2_reg, p2_next;
    logic               sat_reg, sat_next;
    logic [FS_W-1:0]    rem_reg, rem_next;
    logic [DUTY_W-1:0]  quo_reg, quo_next;
    logic [DUTY_W-1:0]  duty_reg, duty_next;
    logic               dir_reg, dir_next;

    logic [FS_W-1:0]       fs_eff;
    logic [IDX_PROD_W-1:0] idx_prod;
    logic [IDX_W-1:0]      idx_raw;
    logic [IDX_W-1:0]      idx_clamped;
    logic [IDX_W-1:0]      idx;
    logic [QSRC_W-1:0]     q_src;
    logic [FS_W:0]         div_try;
    logic [FS_W:0]         div_diff;
    logic                  div_ge;

    always_comb begin
        fs_eff      = (fs_reg == '0) ? FS_W'(1) : fs_reg;
        idx_prod    = IDX_PROD_W'(phase_reg[29:0]) * IDX_PROD_W'(SINE_TABLE_DEPTH);
        idx_raw     = idx_prod[30 +: IDX_W];
        idx_clamped = (idx_raw > IDX_W'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH) : idx_raw;
        idx         = phase_reg[30] ? IDX_W'(SINE_TABLE_DEPTH) - idx_clamped : idx_clamped;
        q_src       = p2_reg[SINE_FRACTION_BITS +: QSRC_W];
        div_try     = {rem_reg, quo_reg[DUTY_W-1]};
        div_diff    = div_try - {1'b0, fs_eff};
        div_ge      = (div_try >= {1'b0, fs_eff});
    end

    // control-side registers: config, phase, step counter
    always_comb begin
        fs_next    = fs_reg;
        dm_next    = dm_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_INTENSITY_FULL_SCALE: fs_next = cfg_wr_data[FS_W-1:0];
                CFG_DUTY_MAX:             dm_next = cfg_wr_data[DUTY_W-1:0];
                default: ;
            endcase
        end
        if (cmd.load) begin
            phase_next = phase_reg + PHASE_INC_ROM[s_frequency_hz];
        end
        if (cmd.prep) begin
            cnt_next = '0;
        end else if (cmd.step) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // payload registers
    always_comb begin
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        inten_nz_next = inten_nz_reg;
        p1_next       = p1_reg;
        lim_next      = lim_reg;
        p2_next       = p2_reg;
        sat_next      = sat_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        duty_next     = duty_reg;
        dir_next      = dir_reg;
        if (cmd.load) begin
            mag_next      = SINE_ROM[idx];
            neg_next      = phase_reg[31];
            inten_nz_next = (s_intensity != '0);
            p1_next       = PROD1_W'(dm_reg) * PROD1_W'(s_intensity);
            lim_next      = (LIM_W'(dm_reg) + LIM_W'(1)) * LIM_W'(fs_eff);
        end
        if (cmd.mul) begin
            p2_next = PROD2_W'(p1_reg) * PROD2_W'(mag_reg);
        end
        if (cmd.prep) begin
            sat_next = (LIM_W'(q_src) >= lim_reg);
            rem_next = q_src[DUTY_W +: FS_W];
            quo_next = q_src[DUTY_W-1:0];
        end
        if (cmd.step) begin
            rem_next = div_ge ? div_diff[FS_W-1:0] : div_try[FS_W-1:0];
            quo_next = {quo_reg[DUTY_W-2:0], div_ge};
        end
        if (cmd.emit) begin
            duty_next = sat_reg ? dm_reg : quo_reg;
            dir_next  = !neg_reg && (mag_reg != '0) && inten_nz_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg    <= FS_RESET;
            dm_reg    <= DUTY_MAX_RESET;
            phase_reg <= '0;
            cnt_reg   <= '0;
        end else begin
            fs_reg    <= fs_next;
            dm_reg    <= dm_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        inten_nz_reg <= inten_nz_next;
        p1_reg       <= p1_next;
        lim_reg      <= lim_next;
        p2_reg       <= p2_next;
        sat_reg      <= sat_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        duty_reg     <= duty_next;
        dir_reg      <= dir_next;
    end

    assign status.div_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    assign m_duty          = duty_reg;
    assign m_direction     = dir_reg;

endmodule

FILE: hdl/sine_pwm_drive_generator.sv
// ---------------------------------------------------------------------------
// sine_pwm_drive_generator
// Sine PWM drive for an H-bridge actuator. Each input transfer is one sample
// tick: the sine of the current phase scaled by intensity gives the duty
// (saturated at duty_max) and the sign gives direction, then the 32-bit phase
// advances by frequency_hz * 2^32 / 10000, a frequency of zero as 1 Hz. The
// transfer edge reads the sine rom and forms the first product; then follow
// the second multiply, the divide setup, the one-bit-per-cycle divider by
// intensity_full_scale, and the load of the output register, which waits
// while the previous result is still not taken. A new item can be taken from
// the cycle after the result is loaded, not before, even while it still
// waits for m_ready. Configuration writes take effect at the next clock edge.
// ---------------------------------------------------------------------------
module sine_pwm_drive_generator import spwm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [FREQ_W-1:0]     s_frequency_hz,
    input  logic [INTEN_W-1:0]    s_intensity,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DUTY_W-1:0]     m_duty,
    output logic                  m_direction
);

    spwm_cmd_t    cmd;
    spwm_status_t status;

    spwm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    spwm_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_frequency_hz (s_frequency_hz),
        .s_intensity    (s_intensity),
        .m_duty         (m_duty),
        .m_direction    (m_direction),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

FILE: hdl/spwm_checker.sv
// ---------------------------------------------------------------------------
// spwm_checker
// port-level checks on transfer sequencing, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spwm_checker import spwm_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DUTY_W-1:0] m_duty,
    input logic              m_direction
);

    // stalled result holds
    `SPWM_ASSERT(a_out_hold, (m_valid && !m_ready |=> m_valid && $stable(m_duty) && $stable(m_direction)), "result changed while stalled")

    // reset empties the output register
    `SPWM_ASSERT_ALWAYS(a_reset_empty, (!aresetn |=> !m_valid), "result valid after reset")

    // one item in work at a time
    `SPWM_ASSERT(a_busy_after_take, (s_valid && s_ready |=> !s_ready), "input taken while busy")

    // no result can follow an input transfer in the next cycle
    `SPWM_ASSERT(a_no_instant_result, (s_valid && s_ready && !m_valid |=> !m_valid), "result too early")

endmodule

bind sine_pwm_drive_generator spwm_checker u_checker (.*);

FILE: test/sine_pwm_drive_generator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sine_pwm_drive_generator_test
// Sends sample ticks with chosen and random frequency and intensity through
// several register settings, including zero and full-range values. Both
// channels stall at random. Every drive result is compared with a duty and
// direction predicted from a private sine table and phase accumulator.
// ---------------------------------------------------------------------------
module sine_pwm_drive_generator_test;
    import spwm_pkg::*;

    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              direction;
    } drive_t;

    class drive_scoreboard;
        logic [MAG_W-1:0]   sine_quarter [0:SINE_TABLE_DEPTH];
        logic [FS_W-1:0]    full_scale;
        logic [DUTY_W-1:0]  duty_limit;
        logic [PHASE_W-1:0] phase;
        drive_t             expected_drive_q [$];
        int                 errors;
        int                 checked;

        function new();
            longint unsigned kk;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned acc;
            longint unsigned den;
            for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
                kk = k;
                x = (kk * HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
                x2 = (x * x) >> 30;
                term = x;
                acc = x;
                for (int n = 1; n <= 8; n++) begin
                    den = (2 * n) * (2 * n + 1);
                    term = ((term * x2) >> 30) / den;
                    if (n % 2 == 1) begin
                        acc = (acc >= term) ? acc - term : 0;
                    end else begin
                        acc = acc + term;
                    end
                end
                acc = (acc + (64'd1 << (29 - SINE_FRACTION_BITS))) >> (30 - SINE_FRACTION_BITS);
                if (acc > (64'd1 << SINE_FRACTION_BITS)) begin
                    acc = 64'd1 << SINE_FRACTION_BITS;
                end
                sine_quarter[k] = acc[MAG_W-1:0];
            end
            full_scale = FS_RESET;
            duty_limit = DUTY_MAX_RESET;
            phase = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_INTENSITY_FULL_SCALE: full_scale = data[FS_W-1:0];
                CFG_DUTY_MAX:             duty_limit = data[DUTY_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_drive_q.size();
        endfunction

        function void note_sample(input logic [FREQ_W-1:0] freq,
                                  input logic [INTEN_W-1:0] inten);
            longint unsigned offset;
            longint unsigned idx;
            longint unsigned scaled;
            longint unsigned divisor;
            longint unsigned step;
            logic [MAG_W-1:0] mag;
            drive_t           d;
            offset = phase[PHASE_W-3:0];
            idx = (offset * SINE_TABLE_DEPTH) >> 30;
            if (phase[PHASE_W-2]) begin
                idx = SINE_TABLE_DEPTH - idx;
            end
            mag = sine_quarter[idx];
            scaled = duty_limit;
            scaled = scaled * inten * mag;
            divisor = (full_scale == 0) ? 1 : full_scale;
            divisor = divisor << SINE_FRACTION_BITS;
            scaled = scaled / divisor;
            if (scaled > duty_limit) begin
                scaled = duty_limit;
            end
            d.duty = scaled[DUTY_W-1:0];
            d.direction = !phase[PHASE_W-1] && mag != 0 && inten != 0;
            expected_drive_q.push_back(d);
            step = (freq == 0) ? 1 : freq;
            step = (step << PHASE_W) / SAMPLE_RATE_HZ;
            phase = phase + step[PHASE_W-1:0];
        endfunction

        function void check_drive(input logic [DUTY_W-1:0] duty, input logic direction);
            drive_t d;
            if (expected_drive_q.size() == 0) begin
                $error("drive transfer with no sample pending: duty %0d direction %0d",
                       duty, direction);
                errors++;
                return;
            end
            d = expected_drive_q.pop_front();
            checked++;
            if (duty !== d.duty) begin
                $error("duty: expected %0d, actual %0d", d.duty, duty);
                errors++;
            end
            if (direction !== d.direction) begin
                $error("direction: expected %0d, actual %0d", d.direction, direction);
                errors++;
            end
        endfunction
    endclass

    localparam int SETTINGS_RUN = 8;
    localparam int RANDOM_PER_SETTING = 200;

    localparam logic [FREQ_W-1:0] EDGE_FREQ [18] = '{
        8'd0, 8'd0, 8'd255, 8'd255, 8'd1, 8'd128, 8'd255, 8'd64, 8'd200,
        8'd37, 8'd255, 8'd0, 8'd170, 8'd85, 8'd255, 8'd99, 8'd2, 8'd250
    };
    localparam logic [INTEN_W-1:0] EDGE_INTEN [18] = '{
        8'd0, 8'd255, 8'd255, 8'd0, 8'd10, 8'd5, 8'd11, 8'd1, 8'd9,
        8'd20, 8'd128, 8'd255, 8'd85, 8'd170, 8'd10, 8'd0, 8'd255, 8'd3
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [FREQ_W-1:0]     s_frequency_hz;
    logic [INTEN_W-1:0]    s_intensity;
    logic                  m_valid;
    logic                  m_ready;
    logic [DUTY_W-1:0]     m_duty;
    logic                  m_direction;

    drive_scoreboard sb;
    bit              idling_on;
    int              samples_sent;

    sine_pwm_drive_generator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_frequency_hz (s_frequency_hz),
        .s_intensity    (s_intensity),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_duty         (m_duty),
        .m_direction    (m_direction)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        if (!idling_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic send_sample(input logic [FREQ_W-1:0] freq, input logic [INTEN_W-1:0] inten);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_frequency_hz = freq;
        s_intensity = inten;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(freq, inten);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (25) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.write_reg(idx, data);
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready = 1'b0;
                stall_left--;
            end else begin
                m_ready = 1'b1;
            end
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_drive(m_duty, m_direction);
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        logic [FS_W-1:0]    fs_pick;
        logic [DUTY_W-1:0]  dmax_pick;
        logic [FREQ_W-1:0]  freq;
        logic [INTEN_W-1:0] inten;
        int                 span;
        sb = new();
        samples_sent = 0;
        idling_on = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_INTENSITY_FULL_SCALE;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_frequency_hz = '0;
        s_intensity = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // reset register values first
        for (int i = 0; i < 18; i++) begin
            send_sample(EDGE_FREQ[i], EDGE_INTEN[i]);
        end

        for (int p = 0; p < SETTINGS_RUN - 1; p++) begin
            drain_results();
            case (p)
                0: begin fs_pick = 8'd1;   dmax_pick = 16'd65535; end
                1: begin fs_pick = 8'd255; dmax_pick = 16'd1;     end
                2: begin fs_pick = 8'd0;   dmax_pick = 16'd40000; end
                3: begin fs_pick = 8'd10;  dmax_pick = 16'd0;     end
                4: begin fs_pick = 8'd255; dmax_pick = 16'd65535; end
                default: begin
                    fs_pick = FS_W'($urandom_range(1, 255));
                    dmax_pick = DUTY_W'($urandom_range(1, 65535));
                end
            endcase
            write_reg(CFG_INTENSITY_FULL_SCALE, {{(CFG_DATA_W-FS_W){1'b0}}, fs_pick});
            write_reg(CFG_DUTY_MAX, dmax_pick);
            idling_on = (p != 1);
            span = 2 * fs_pick + 1;
            if (span > 255) begin
                span = 255;
            end
            for (int i = 0; i < RANDOM_PER_SETTING; i++) begin
                if (p == 3 && i == RANDOM_PER_SETTING / 2) begin
                    drain_results();
                end
                case ($urandom_range(0, 9))
                    0: freq = 8'd0;
                    1: freq = 8'd255;
                    default: freq = FREQ_W'($urandom_range(0, 255));
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    inten = INTEN_W'($urandom_range(0, span));
                end else begin
                    inten = INTEN_W'($urandom_range(0, 255));
                end
                send_sample(freq, inten);
            end
        end

        drain_results();
        $display("sent %0d sample ticks over %0d register settings, %0d drive results checked",
                 samples_sent, SETTINGS_RUN, sb.checked);
        $display("settings spanned full-scale 0/1/255 and duty limit 0/1/65535 with stalls");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("sine_pwm_drive_generator: match");
        end else begin
            $display("sine_pwm_drive_generator: mismatch");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("sine_pwm_drive_generator: mismatch");
        $finish;
    end

endmodule
